// ===== hw/rtl/dte_pkg.sv =====
// ---------------------------------------------------------------------------
// dte_pkg: shared types and constants of the DNS TXT answer extractor
// Holds the result kinds, status codes, parse phases and the entry format
// passed from the parsing front to the emitting back.
// ---------------------------------------------------------------------------
`default_nettype none

package dte_pkg;

   localparam int MAX_PACKET  = 1024;
   localparam int OFFSET_W    = $clog2(MAX_PACKET + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] WANTED_TYPE_RESET = 16'd16;

   // header layout and fixed field lengths
   localparam logic [3:0] QFIXED_LEN   = 4'd4;
   localparam logic [3:0] AFIXED_LEN   = 4'd10;
   localparam logic [3:0] AF_TYPE_HI   = 4'd0;
   localparam logic [3:0] AF_TYPE_LO   = 4'd1;
   localparam logic [3:0] AF_RDLEN_HI  = 4'd8;
   localparam logic [3:0] AF_RDLEN_LO  = 4'd9;
   localparam logic [OFFSET_W-1:0] HDR_QD_HI = OFFSET_W'(4);
   localparam logic [OFFSET_W-1:0] HDR_QD_LO = OFFSET_W'(5);
   localparam logic [OFFSET_W-1:0] HDR_AN_HI = OFFSET_W'(6);
   localparam logic [OFFSET_W-1:0] HDR_AN_LO = OFFSET_W'(7);
   localparam logic [OFFSET_W-1:0] HDR_LAST  = OFFSET_W'(11);

   // result kinds
   localparam logic [1:0] KIND_TEXT   = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // packet status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_TRUNC    = 3'd1;
   localparam logic [2:0] ST_OVERRUN  = 3'd2;
   localparam logic [2:0] ST_BADLABEL = 3'd3;
   localparam logic [2:0] ST_NOREC    = 3'd4;

   typedef enum logic [13:0] {
      PH_HEADER   = 14'b00000000000001,
      PH_QNAME    = 14'b00000000000010,
      PH_QLABEL   = 14'b00000000000100,
      PH_QPTR     = 14'b00000000001000,
      PH_QFIXED   = 14'b00000000010000,
      PH_ANAME    = 14'b00000000100000,
      PH_ALABEL   = 14'b00000001000000,
      PH_APTR     = 14'b00000010000000,
      PH_AFIXED   = 14'b00000100000000,
      PH_STRLEN   = 14'b00001000000000,
      PH_STR      = 14'b00010000000000,
      PH_SKIP     = 14'b00100000000000,
      PH_FINISHED = 14'b01000000000000,
      PH_HALTED   = 14'b10000000000000
   } phase_type;

   // all results caused by one packet byte, in emission order text, end, status
   typedef struct packed {
      logic       has_text;
      logic       has_end;
      logic       has_status;
      logic [7:0] text;
      logic [2:0] status;
   } entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dte_front.sv =====
// ---------------------------------------------------------------------------
// dte_front: DNS response parser
// Walks header, questions and answers one byte per transfer and forms the
// result entry caused by each byte.
// ---------------------------------------------------------------------------
`default_nettype none

module dte_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_wr_en,
   input  wire  [15:0]         csr_wr_data,
   input  wire                 byte_valid,
   input  wire  [7:0]          packet_byte,
   input  wire                 packet_end,
   output dte_pkg::entry_type  entry,
   output logic                entry_valid
);

   dte_pkg::phase_type            phase_ff, phase_in;
   logic [dte_pkg::OFFSET_W-1:0]  offset_ff, offset_in;
   logic [15:0]                   qleft_ff, qleft_in;
   logic [15:0]                   aleft_ff, aleft_in;
   logic [3:0]                    fixed_ff, fixed_in;
   logic [15:0]                   atype_ff, atype_in;
   logic [15:0]                   rdleft_ff, rdleft_in;
   logic [7:0]                    strleft_ff, strleft_in;
   logic [5:0]                    lblleft_ff, lblleft_in;
   logic                          found_ff, found_in;
   logic [2:0]                    err_ff, err_in;
   logic [15:0]                   wanted_ff;
   logic [15:0]                   aleft_dec;
   logic [15:0]                   rd_dec;
   logic [3:0]                    fixed_inc;
   logic                          rec_done;
   logic                          ans_done;

   assign aleft_dec = aleft_ff - 16'd1;
   assign rd_dec    = rdleft_ff - 16'd1;
   assign fixed_inc = fixed_ff + 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      offset_in  = offset_ff;
      qleft_in   = qleft_ff;
      aleft_in   = aleft_ff;
      fixed_in   = fixed_ff;
      atype_in   = atype_ff;
      rdleft_in  = rdleft_ff;
      strleft_in = strleft_ff;
      lblleft_in = lblleft_ff;
      found_in   = found_ff;
      err_in     = err_ff;
      rec_done   = 1'b0;
      ans_done   = 1'b0;
      entry      = '0;

      if (offset_ff < dte_pkg::OFFSET_W'(dte_pkg::MAX_PACKET)) begin
         offset_in = offset_ff + dte_pkg::OFFSET_W'(1);
         case (phase_ff)
            dte_pkg::PH_HEADER: begin
               if (offset_ff == dte_pkg::HDR_QD_HI) qleft_in = {packet_byte, 8'd0};
               else if (offset_ff == dte_pkg::HDR_QD_LO) qleft_in = {qleft_ff[15:8], packet_byte};
               else if (offset_ff == dte_pkg::HDR_AN_HI) aleft_in = {packet_byte, 8'd0};
               else if (offset_ff == dte_pkg::HDR_AN_LO) aleft_in = {aleft_ff[15:8], packet_byte};
               else if (offset_ff == dte_pkg::HDR_LAST) begin
                  if (qleft_ff == 16'd0)
                     phase_in = (aleft_ff == 16'd0) ? dte_pkg::PH_FINISHED : dte_pkg::PH_ANAME;
                  else
                     phase_in = dte_pkg::PH_QNAME;
               end
            end
            dte_pkg::PH_QNAME, dte_pkg::PH_ANAME: begin
               if (packet_byte == 8'd0) begin
                  fixed_in = 4'd0;
                  phase_in = (phase_ff == dte_pkg::PH_QNAME) ? dte_pkg::PH_QFIXED
                                                             : dte_pkg::PH_AFIXED;
               end else if (packet_byte[7:6] == 2'b11) begin
                  phase_in = (phase_ff == dte_pkg::PH_QNAME) ? dte_pkg::PH_QPTR
                                                             : dte_pkg::PH_APTR;
               end else if (packet_byte[7:6] != 2'b00) begin
                  err_in   = dte_pkg::ST_BADLABEL;
                  phase_in = dte_pkg::PH_HALTED;
               end else begin
                  lblleft_in = packet_byte[5:0];
                  phase_in = (phase_ff == dte_pkg::PH_QNAME) ? dte_pkg::PH_QLABEL
                                                             : dte_pkg::PH_ALABEL;
               end
            end
            dte_pkg::PH_QLABEL: begin
               lblleft_in = lblleft_ff - 6'd1;
               if (lblleft_ff == 6'd1) phase_in = dte_pkg::PH_QNAME;
            end
            dte_pkg::PH_ALABEL: begin
               lblleft_in = lblleft_ff - 6'd1;
               if (lblleft_ff == 6'd1) phase_in = dte_pkg::PH_ANAME;
            end
            dte_pkg::PH_QPTR: begin
               fixed_in = 4'd0;
               phase_in = dte_pkg::PH_QFIXED;
            end
            dte_pkg::PH_APTR: begin
               fixed_in = 4'd0;
               phase_in = dte_pkg::PH_AFIXED;
            end
            dte_pkg::PH_QFIXED: begin
               fixed_in = fixed_inc;
               if (fixed_inc >= dte_pkg::QFIXED_LEN) begin
                  fixed_in = 4'd0;
                  qleft_in = qleft_ff - 16'd1;
                  if (qleft_ff == 16'd1)
                     phase_in = (aleft_ff == 16'd0) ? dte_pkg::PH_FINISHED : dte_pkg::PH_ANAME;
                  else
                     phase_in = dte_pkg::PH_QNAME;
               end
            end
            dte_pkg::PH_AFIXED: begin
               if (fixed_ff == dte_pkg::AF_TYPE_HI) atype_in = {packet_byte, 8'd0};
               else if (fixed_ff == dte_pkg::AF_TYPE_LO) atype_in = {atype_ff[15:8], packet_byte};
               else if (fixed_ff == dte_pkg::AF_RDLEN_HI) rdleft_in = {packet_byte, 8'd0};
               else if (fixed_ff == dte_pkg::AF_RDLEN_LO)
                  rdleft_in = {rdleft_ff[15:8], packet_byte};
               fixed_in = fixed_inc;
               if (fixed_inc >= dte_pkg::AFIXED_LEN) begin
                  fixed_in = 4'd0;
                  // rdata length low byte arrives on this very byte
                  if (atype_ff == wanted_ff) begin
                     if (rdleft_in == 16'd0) rec_done = 1'b1;
                     else phase_in = dte_pkg::PH_STRLEN;
                  end else begin
                     if (rdleft_in == 16'd0) ans_done = 1'b1;
                     else phase_in = dte_pkg::PH_SKIP;
                  end
               end
            end
            dte_pkg::PH_STRLEN: begin
               rdleft_in = rd_dec;
               if (packet_byte > rd_dec[7:0] && rd_dec[15:8] == 8'd0) begin
                  err_in   = dte_pkg::ST_OVERRUN;
                  phase_in = dte_pkg::PH_HALTED;
               end else if (packet_byte == 8'd0) begin
                  if (rd_dec == 16'd0) rec_done = 1'b1;
               end else begin
                  strleft_in = packet_byte;
                  phase_in   = dte_pkg::PH_STR;
               end
            end
            dte_pkg::PH_STR: begin
               entry.has_text = 1'b1;
               entry.text     = packet_byte;
               rdleft_in      = rd_dec;
               strleft_in     = strleft_ff - 8'd1;
               if (strleft_ff == 8'd1) begin
                  if (rd_dec == 16'd0) rec_done = 1'b1;
                  else phase_in = dte_pkg::PH_STRLEN;
               end
            end
            dte_pkg::PH_SKIP: begin
               rdleft_in = rd_dec;
               if (rd_dec == 16'd0) ans_done = 1'b1;
            end
            default: begin
            end
         endcase

         // close the record, then advance to the next answer
         if (rec_done) begin
            entry.has_end = 1'b1;
            found_in      = 1'b1;
         end
         if (rec_done || ans_done) begin
            aleft_in = aleft_dec;
            phase_in = (aleft_dec == 16'd0) ? dte_pkg::PH_FINISHED : dte_pkg::PH_ANAME;
         end
      end

      if (packet_end) begin
         entry.has_status = 1'b1;
         if (err_in != dte_pkg::ST_OK) entry.status = err_in;
         else if (phase_in != dte_pkg::PH_FINISHED) entry.status = dte_pkg::ST_TRUNC;
         else if (!found_in) entry.status = dte_pkg::ST_NOREC;
         else entry.status = dte_pkg::ST_OK;
         // start over on a new packet
         phase_in   = dte_pkg::PH_HEADER;
         offset_in  = '0;
         qleft_in   = '0;
         aleft_in   = '0;
         fixed_in   = '0;
         atype_in   = '0;
         rdleft_in  = '0;
         strleft_in = '0;
         lblleft_in = '0;
         found_in   = 1'b0;
         err_in     = dte_pkg::ST_OK;
      end
   end

   assign entry_valid = byte_valid && (entry.has_text || entry.has_end || entry.has_status);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= dte_pkg::PH_HEADER;
         offset_ff  <= '0;
         qleft_ff   <= '0;
         aleft_ff   <= '0;
         fixed_ff   <= '0;
         atype_ff   <= '0;
         rdleft_ff  <= '0;
         strleft_ff <= '0;
         lblleft_ff <= '0;
         found_ff   <= 1'b0;
         err_ff     <= dte_pkg::ST_OK;
         wanted_ff  <= dte_pkg::WANTED_TYPE_RESET;
      end else begin
         if (csr_wr_en) wanted_ff <= csr_wr_data;
         if (byte_valid) begin
            phase_ff   <= phase_in;
            offset_ff  <= offset_in;
            qleft_ff   <= qleft_in;
            aleft_ff   <= aleft_in;
            fixed_ff   <= fixed_in;
            atype_ff   <= atype_in;
            rdleft_ff  <= rdleft_in;
            strleft_ff <= strleft_in;
            lblleft_ff <= lblleft_in;
            found_ff   <= found_in;
            err_ff     <= err_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dte_queue.sv =====
// ---------------------------------------------------------------------------
// dte_queue: result entry queue
// Short first-in first-out buffer between the parser and the emitter.
// ---------------------------------------------------------------------------
`default_nettype none

module dte_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire dte_pkg::entry_type  push_data,
   input  wire                      pop,
   output dte_pkg::entry_type       head,
   output logic                     not_empty,
   output logic                     full
);

   dte_pkg::entry_type             slot_ff [dte_pkg::QUEUE_DEPTH];
   logic [dte_pkg::QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [dte_pkg::QUEUE_CW-1:0]   count_ff, count_in;
   logic                           do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == dte_pkg::QUEUE_CW'(dte_pkg::QUEUE_DEPTH));
   assign head      = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) count_in = count_ff + dte_pkg::QUEUE_CW'(1);
      else if (!push && do_pop) count_in = count_ff - dte_pkg::QUEUE_CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + dte_pkg::QUEUE_AW'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + dte_pkg::QUEUE_AW'(1);
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dte_back.sv =====
// ---------------------------------------------------------------------------
// dte_back: result emitter
// Unpacks each queued entry into text, record-end and status items and
// drives them through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module dte_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire dte_pkg::entry_type  head,
   input  wire                      head_valid,
   output logic                     pop,
   output logic                     out_valid,
   input  wire                      out_ready,
   output logic [1:0]               out_kind,
   output logic [7:0]               out_text,
   output logic [2:0]               out_status
);

   logic [7:0]  text_ff;
   logic [2:0]  status_ff;
   logic [2:0]  pend_ff, pend_in;     // [0] text, [1] record end, [2] status
   logic [2:0]  pick;
   logic        out_free;
   logic        take;
   logic        valid_ff;
   logic [1:0]  kind_ff;
   logic [7:0]  otext_ff;
   logic [2:0]  ostatus_ff;

   assign out_free = !valid_ff || out_ready;
   assign take     = out_free && (pend_ff != 3'd0);

   always_comb begin
      if (pend_ff[0]) pick = 3'b001;
      else if (pend_ff[1]) pick = 3'b010;
      else pick = 3'b100;
      pend_in = take ? (pend_ff & ~pick) : pend_ff;
   end

   assign pop = head_valid && (pend_in == 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff <= pop ? {head.has_status, head.has_end, head.has_text} : pend_in;
         if (take) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         text_ff   <= head.text;
         status_ff <= head.status;
      end
      if (take) begin
         otext_ff   <= pick[0] ? text_ff : 8'd0;
         ostatus_ff <= pick[2] ? status_ff : dte_pkg::ST_OK;
         if (pick[0]) kind_ff <= dte_pkg::KIND_TEXT;
         else if (pick[1]) kind_ff <= dte_pkg::KIND_END;
         else kind_ff <= dte_pkg::KIND_STATUS;
      end
   end

   assign out_valid  = valid_ff;
   assign out_kind   = kind_ff;
   assign out_text   = otext_ff;
   assign out_status = ostatus_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dns_txt_answer_extractor.sv =====
// ---------------------------------------------------------------------------
// dns_txt_answer_extractor: DNS response TXT record extractor
// Parses a DNS response byte stream and emits the character-string bytes of
// every answer of the configured type, record-end markers and a status.
// ---------------------------------------------------------------------------
//
//   channel  direction  contents
//   req_*    in         one response byte per transfer, tlast on final byte
//   rsp_*    out        text byte, record end or packet status per transfer
//   csr_*    in         wanted_type register write, no read-back
//
// The parser takes one byte per cycle: req_tready is high unless the result
// queue is full, independent of the parse state. A byte yields zero to three
// result items (text, record end, status); the emitter sends one per cycle while
// rsp_tready is high, so runs of multi-item bytes fill the 4-entry queue and stall
// the input. The output is registered. Reset (synchronous) clears the parse
// state and sets wanted_type to 16. rsp_tready low holds the output register;
// the parser keeps going until the queue fills.
// ---------------------------------------------------------------------------
`default_nettype none

module dns_txt_answer_extractor (
   input  wire          clock,
   input  wire          reset,
   // configuration
   input  wire          csr_wr_en,
   input  wire  [15:0]  csr_wr_data,     // wanted_type
   // request stream
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,       // [7:0] packet_byte
   input  wire          req_tlast,       // packet_end
   // result stream
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [15:0]  rsp_tdata,       // [7:0] text_byte, [10:8] status_code, rest 0
   output logic [1:0]   rsp_tuser        // [1:0] item_kind
);

   dte_pkg::entry_type  new_entry;
   dte_pkg::entry_type  head;
   logic                new_valid;
   logic                q_full;
   logic                q_not_empty;
   logic                q_pop;
   logic                byte_xfer;
   logic [7:0]          text_byte;
   logic [2:0]          status_code;

   // accept a byte whenever the queue has room for its results
   assign req_tready = !q_full;
   assign byte_xfer  = req_tvalid && req_tready;

   dte_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .byte_valid  (byte_xfer),
      .packet_byte (req_tdata),
      .packet_end  (req_tlast),
      .entry       (new_entry),
      .entry_valid (new_valid)
   );

   dte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (new_valid),
      .push_data (new_entry),
      .pop       (q_pop),
      .head      (head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   dte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (q_not_empty),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (rsp_tuser),
      .out_text   (text_byte),
      .out_status (status_code)
   );

   assign rsp_tdata = {5'd0, status_code, text_byte};

endmodule

`default_nettype wire

// ===== tb/sv/tb_dns_txt_answer_extractor.sv =====
// ---------------------------------------------------------------------------
// tb_dns_txt_answer_extractor: self-checking bench for the TXT extractor
// Streams DNS responses into the parser, some well formed and some broken.
// A scoreboard follows the parse of every accepted byte and checks each
// result transfer in order. The run goes through four handshake pressure
// phases, and wanted_type is rewritten at the start of each phase.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_dns_txt_answer_extractor;

   timeunit 1ns;
   timeprecision 1ps;

   // one result transfer as seen on rsp_*
   typedef struct {
      logic [1:0] kind;
      logic [7:0] text;
      logic [2:0] status;
   } txt_item_type;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the parse of each accepted byte and holds the results
   // still to come, oldest first.
   // -------------------------------------------------------------------------
   class txt_extract_scoreboard;
      logic [15:0]         wanted_type;
      dte_pkg::phase_type  phase;
      int unsigned         byte_offset;
      logic [15:0]         questions_left;
      logic [15:0]         answers_left;
      logic [3:0]          fixed_count;
      logic [15:0]         answer_type;
      logic [15:0]         rdata_left;
      logic [7:0]          string_left;
      logic [5:0]          label_left;
      logic [15:0]         records_found;
      logic [2:0]          error_status;
      txt_item_type        expected_items[$];
      int                  mismatches;

      function new();
         wanted_type = dte_pkg::WANTED_TYPE_RESET;
         mismatches  = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         phase          = dte_pkg::PH_HEADER;
         byte_offset    = 0;
         questions_left = '0;
         answers_left   = '0;
         fixed_count    = '0;
         answer_type    = '0;
         rdata_left     = '0;
         string_left    = '0;
         label_left     = '0;
         records_found  = '0;
         error_status   = dte_pkg::ST_OK;
      endfunction

      function void set_wanted(logic [15:0] value);
         wanted_type = value;
      endfunction

      function int pending();
         return expected_items.size();
      endfunction

      function void push_item(logic [1:0] kind, logic [7:0] text, logic [2:0] status);
         txt_item_type item;
         item.kind   = kind;
         item.text   = text;
         item.status = status;
         expected_items.push_back(item);
      endfunction

      function void halt(logic [2:0] code);
         error_status = code;
         phase        = dte_pkg::PH_HALTED;
      endfunction

      function void open_answers();
         phase = (answers_left == 16'd0) ? dte_pkg::PH_FINISHED : dte_pkg::PH_ANAME;
      endfunction

      function void finish_answer();
         answers_left = answers_left - 16'd1;
         open_answers();
      endfunction

      function void close_record();
         push_item(dte_pkg::KIND_END, 8'h00, dte_pkg::ST_OK);
         if (records_found != 16'hFFFF)
            records_found = records_found + 16'd1;
         finish_answer();
      endfunction

      // zero ends the name, 11 starts a pointer, 00 a label, 01 and 10 are bad
      function void take_name_byte(logic [7:0] b, dte_pkg::phase_type label_ph,
                                   dte_pkg::phase_type ptr_ph,
                                   dte_pkg::phase_type end_ph);
         if (b == 8'h00) begin
            fixed_count = '0;
            phase       = end_ph;
         end else if (b[7:6] == 2'b11) begin
            phase = ptr_ph;
         end else if (b[7:6] != 2'b00) begin
            halt(dte_pkg::ST_BADLABEL);
         end else begin
            label_left = b[5:0];
            phase      = label_ph;
         end
      endfunction

      function void parse_byte(logic [7:0] b);
         case (phase)
            dte_pkg::PH_HEADER: begin
               if (byte_offset == dte_pkg::HDR_QD_HI)
                  questions_left = {b, 8'h00};
               else if (byte_offset == dte_pkg::HDR_QD_LO)
                  questions_left = questions_left | 16'(b);
               else if (byte_offset == dte_pkg::HDR_AN_HI)
                  answers_left = {b, 8'h00};
               else if (byte_offset == dte_pkg::HDR_AN_LO)
                  answers_left = answers_left | 16'(b);
               else if (byte_offset == dte_pkg::HDR_LAST) begin
                  if (questions_left == 16'd0) open_answers();
                  else phase = dte_pkg::PH_QNAME;
               end
            end
            dte_pkg::PH_QNAME:
               take_name_byte(b, dte_pkg::PH_QLABEL, dte_pkg::PH_QPTR, dte_pkg::PH_QFIXED);
            dte_pkg::PH_QLABEL: begin
               label_left = label_left - 6'd1;
               if (label_left == 6'd0) phase = dte_pkg::PH_QNAME;
            end
            dte_pkg::PH_QPTR: begin
               fixed_count = '0;
               phase       = dte_pkg::PH_QFIXED;
            end
            dte_pkg::PH_QFIXED: begin
               fixed_count = fixed_count + 4'd1;
               if (fixed_count >= dte_pkg::QFIXED_LEN) begin
                  fixed_count    = '0;
                  questions_left = questions_left - 16'd1;
                  if (questions_left == 16'd0) open_answers();
                  else phase = dte_pkg::PH_QNAME;
               end
            end
            dte_pkg::PH_ANAME:
               take_name_byte(b, dte_pkg::PH_ALABEL, dte_pkg::PH_APTR, dte_pkg::PH_AFIXED);
            dte_pkg::PH_ALABEL: begin
               label_left = label_left - 6'd1;
               if (label_left == 6'd0) phase = dte_pkg::PH_ANAME;
            end
            dte_pkg::PH_APTR: begin
               fixed_count = '0;
               phase       = dte_pkg::PH_AFIXED;
            end
            dte_pkg::PH_AFIXED: begin
               if (fixed_count == dte_pkg::AF_TYPE_HI)
                  answer_type = {b, 8'h00};
               else if (fixed_count == dte_pkg::AF_TYPE_LO)
                  answer_type = answer_type | 16'(b);
               else if (fixed_count == dte_pkg::AF_RDLEN_HI)
                  rdata_left = {b, 8'h00};
               else if (fixed_count == dte_pkg::AF_RDLEN_LO)
                  rdata_left = rdata_left | 16'(b);
               fixed_count = fixed_count + 4'd1;
               if (fixed_count >= dte_pkg::AFIXED_LEN) begin
                  fixed_count = '0;
                  if (answer_type == wanted_type) begin
                     if (rdata_left == 16'd0) close_record();
                     else phase = dte_pkg::PH_STRLEN;
                  end else begin
                     if (rdata_left == 16'd0) finish_answer();
                     else phase = dte_pkg::PH_SKIP;
                  end
               end
            end
            dte_pkg::PH_STRLEN: begin
               rdata_left = rdata_left - 16'd1;
               if (16'(b) > rdata_left) begin
                  halt(dte_pkg::ST_OVERRUN);
               end else if (b == 8'h00) begin
                  if (rdata_left == 16'd0) close_record();
               end else begin
                  string_left = b;
                  phase       = dte_pkg::PH_STR;
               end
            end
            dte_pkg::PH_STR: begin
               push_item(dte_pkg::KIND_TEXT, b, dte_pkg::ST_OK);
               rdata_left  = rdata_left - 16'd1;
               string_left = string_left - 8'd1;
               if (string_left == 8'd0) begin
                  if (rdata_left == 16'd0) close_record();
                  else phase = dte_pkg::PH_STRLEN;
               end
            end
            dte_pkg::PH_SKIP: begin
               rdata_left = rdata_left - 16'd1;
               if (rdata_left == 16'd0) finish_answer();
            end
            default: ;
         endcase
      endfunction

      // note one accepted request transfer
      function void note_byte(logic [7:0] b, logic last);
         logic [2:0] status;
         if (byte_offset < dte_pkg::MAX_PACKET) begin
            parse_byte(b);
            byte_offset++;
         end
         if (last) begin
            if (error_status != dte_pkg::ST_OK)      status = error_status;
            else if (phase != dte_pkg::PH_FINISHED)  status = dte_pkg::ST_TRUNC;
            else if (records_found == 16'd0)         status = dte_pkg::ST_NOREC;
            else                                     status = dte_pkg::ST_OK;
            push_item(dte_pkg::KIND_STATUS, 8'h00, status);
            clear_packet();
         end
      endfunction

      // check one accepted result transfer against the oldest expectation
      function void check_item(logic [1:0] kind, logic [7:0] text, logic [2:0] status);
         txt_item_type want;
         if (expected_items.size() == 0) begin
            $error("unexpected result: item_kind %0d text_byte 0x%02h status_code %0d",
                   kind, text, status);
            mismatches++;
            return;
         end
         want = expected_items.pop_front();
         if (kind !== want.kind) begin
            $error("item_kind: expected %0d, got %0d", want.kind, kind);
            mismatches++;
         end
         if (text !== want.text) begin
            $error("text_byte: expected 0x%02h, got 0x%02h", want.text, text);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status_code: expected %0d, got %0d", want.status, status);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;   // [7:0] packet_byte
   logic        req_tlast   = 1'b0;    // packet_end
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;             // [7:0] text_byte, [10:8] status_code
   logic [1:0]  rsp_tuser;             // [1:0] item_kind

   always #4 clock = ~clock;

   dns_txt_answer_extractor i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   txt_extract_scoreboard sb = new();

   localparam int PHASE_BUDGET = 74;  // request bytes per pressure phase

   int unsigned send_idle_pct  = 0;   // chance per byte slot that the sender holds off
   int unsigned recv_stall_pct = 0;   // chance per cycle that the receiver stalls
   logic [15:0] wanted_now     = dte_pkg::WANTED_TYPE_RESET;
   logic [7:0]  pkt_bytes[$];         // response being built
   logic [7:0]  rdata_bytes[$];       // rdata of the answer being built

   // Receiver: stall at random, at the configured rate.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Result monitor: values read here are those from before the edge.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_item(rsp_tuser, rsp_tdata[7:0], rsp_tdata[10:8]);

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("** dns_txt_answer_extractor: FAILED **");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response builders
   // -------------------------------------------------------------------------

   // Append a name: a few labels, then a zero byte or a compression pointer.
   // A bad name is one byte with top bits 01 or 10.
   function automatic void add_name(bit bad);
      int nlab;
      int len;
      if (bad) begin
         pkt_bytes.push_back(8'($urandom_range(8'h40, 8'hBF)));
         return;
      end
      nlab = $urandom_range(0, 3);
      repeat (nlab) begin
         len = ($urandom_range(29) == 0) ? 63 : $urandom_range(1, 5);
         pkt_bytes.push_back(8'(len));
         repeat (len) pkt_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(1) == 0) begin
         pkt_bytes.push_back(8'h00);
      end else begin
         pkt_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
         pkt_bytes.push_back(8'($urandom));
      end
   endfunction

   // Build rdata as character-strings; an overrun inflates the first length.
   function automatic void build_rdata(bit overrun);
      int nstr;
      int len;
      int over;
      rdata_bytes.delete();
      nstr = $urandom_range(0, 3);
      if (overrun && nstr == 0) nstr = 1;
      repeat (nstr) begin
         len = ($urandom_range(39) == 0) ? 255 : $urandom_range(0, 6);
         rdata_bytes.push_back(8'(len));
         repeat (len) rdata_bytes.push_back(8'($urandom));
      end
      if (overrun) begin
         over = rdata_bytes.size() - 1 + $urandom_range(1, 3);
         rdata_bytes[0] = (over > 255) ? 8'hFF : 8'(over);
      end
   endfunction

   // Build one response: mostly well formed with random content, the rest
   // noise, bad labels, string overruns, trailing bytes, a huge answer count or cut short.
   function automatic void build_packet(logic [15:0] wanted);
      int          variant;
      int          qd;
      int          an;
      int          bad_at;
      int          overrun_at;
      int          cut;
      logic [15:0] rtype;
      pkt_bytes.delete();
      variant = $urandom_range(99);
      if (variant < 5) begin
         repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
         return;
      end
      qd = $urandom_range(0, 2);
      an = $urandom_range(0, 3);
      bad_at     = (variant < 13 && qd + an > 0) ? $urandom_range(0, qd + an - 1) : -1;
      overrun_at = (variant >= 13 && variant < 21 && an > 0) ? $urandom_range(0, an - 1) : -1;

      // header: id and flags, counts, then the authority and additional counts
      repeat (4) pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(8'(qd));
      // a huge answer count now and then leaves the parse unfinished
      pkt_bytes.push_back((variant >= 97) ? 8'($urandom) : 8'h00);
      pkt_bytes.push_back(8'(an));
      repeat (4) pkt_bytes.push_back(8'($urandom));

      for (int q = 0; q < qd; q++) begin
         add_name(bad_at == q);
         repeat (4) pkt_bytes.push_back(8'($urandom));
      end
      for (int a = 0; a < an; a++) begin
         add_name(bad_at == qd + a);
         rtype = (a == overrun_at || $urandom_range(3) != 0) ? wanted : 16'($urandom);
         pkt_bytes.push_back(rtype[15:8]);
         pkt_bytes.push_back(rtype[7:0]);
         repeat (6) pkt_bytes.push_back(8'($urandom));   // class and TTL
         build_rdata(a == overrun_at);
         pkt_bytes.push_back(8'(rdata_bytes.size() >> 8));
         pkt_bytes.push_back(8'(rdata_bytes.size()));
         foreach (rdata_bytes[k]) pkt_bytes.push_back(rdata_bytes[k]);
      end

      if (variant >= 21 && variant < 29)
         repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom));
      if (variant >= 29 && variant < 39 && pkt_bytes.size() > 1) begin
         cut = $urandom_range(1, pkt_bytes.size() - 1);
         while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Offer one byte after a random hold-off, and wait for its transfer.
   // tvalid stays high afterwards so the next byte can follow back to back.
   task automatic send_byte(logic [7:0] b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b, last);
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt_bytes.size(); i++)
         send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
   endtask

   // Drop tvalid and hold until every expected result has been seen.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write wanted_type only once the block is idle; let the pipeline settle
   // first, since trailing bytes may still be in flight without results.
   task automatic write_wanted(logic [15:0] value);
      wait_drain();
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_wanted(value);
      wanted_now = value;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   int unsigned idle_by_phase[4]  = '{0, 72, 0, 7};
   int unsigned stall_by_phase[4] = '{0, 0, 72, 7};
   logic [15:0] wanted_by_phase[4];
   int          phase_bytes;

   initial begin
      wanted_by_phase = '{16'd16, 16'h0000, 16'hFFFF, 16'($urandom)};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a one-byte packet and a short header both end truncated;
      // a bare header with no questions or answers reports no records.
      pkt_bytes = '{8'hA5};
      send_packet();
      pkt_bytes = '{8'h00, 8'hFF, 8'h5A};
      send_packet();
      pkt_bytes = '{8'hFF, 8'h00, 8'h81, 8'h80, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_packet();

      // Random: one pressure phase per wanted_type setting.
      for (int ph = 0; ph < 4; ph++) begin
         write_wanted(wanted_by_phase[ph]);
         send_idle_pct  = idle_by_phase[ph];
         recv_stall_pct = stall_by_phase[ph];
         phase_bytes = 0;
         while (phase_bytes < PHASE_BUDGET) begin
            build_packet(wanted_now);
            // cut the last packet of the phase short to keep the byte count
            while (pkt_bytes.size() > PHASE_BUDGET - phase_bytes)
               void'(pkt_bytes.pop_back());
            send_packet();
            phase_bytes += pkt_bytes.size();
            // now and then hold the sender until the output side has drained
            if ($urandom_range(7) == 0) wait_drain();
         end
      end

      wait_drain();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("** dns_txt_answer_extractor: PASSED **");
      else
         $display("** dns_txt_answer_extractor: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
